// File: design/nec_ir_pkg.sv
// ----------------------------------------------------------------------------
// NEC IR transmitter package
// Item types, register indexes, reset values and frame constants shared by
// the transmitter RTL.
// ----------------------------------------------------------------------------
package nec_ir_pkg;

    // Input item: a timing tick or a request to send a frame.
    typedef struct packed {
        logic       req_type;
        logic [7:0] address_byte;
        logic [7:0] command_byte;
    } t_in_item;

    // Result item: one per input item.
    typedef struct packed {
        logic ir_level;
        logic busy_res;
        logic accepted;
        logic frame_done;
    } t_out_item;

    // Request type codes.
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_SEND = 1'b1;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_CARRIER_PERIOD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEADER_MARK    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEADER_SPACE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_MARK       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_SPACE      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_SPACE     = 3'd5;

    // Register reset values.
    localparam logic [7:0]  RST_CARRIER_PERIOD = 8'd26;
    localparam logic [15:0] RST_LEADER_MARK    = 16'd9000;
    localparam logic [15:0] RST_LEADER_SPACE   = 16'd4500;
    localparam logic [15:0] RST_BIT_MARK       = 16'd560;
    localparam logic [15:0] RST_ONE_SPACE      = 16'd1690;
    localparam logic [15:0] RST_ZERO_SPACE     = 16'd560;

    // Segments: leader mark, leader space, 64 bit segments, stop mark.
    localparam int unsigned SEG_W = 7;
    localparam logic [SEG_W-1:0] SEG_LEADER_MARK  = 7'd0;
    localparam logic [SEG_W-1:0] SEG_LEADER_SPACE = 7'd1;
    localparam logic [SEG_W-1:0] SEG_FIRST_BIT    = 7'd2;
    localparam logic [SEG_W-1:0] SEG_STOP         = 7'd66;

endpackage

// File: design/nec_ir_transmitter_top.sv
// ----------------------------------------------------------------------------
// NEC IR transmitter, top level
// Throughput: one item per cycle while the output buffer does not stall the
// input; the segment, timer and carrier state is updated by a single pass of
// logic at each accepted item.
// A two-entry output buffer lets input continue while one result is stalled.
// Reset (synchronous, active low) returns the block to idle with the
// configuration registers at their default NEC timings.
// ----------------------------------------------------------------------------
module nec_ir_transmitter_top #(
    parameter int unsigned TIMER_WIDTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Input channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  nec_ir_pkg::t_in_item                 i_in_data,
    // Output channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output nec_ir_pkg::t_out_item                o_out_data,
    // Configuration write channel
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [nec_ir_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [nec_ir_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam logic [31:0] TIMER_MAX = 32'((64'd1 << TIMER_WIDTH) - 64'd1);

    // Configuration registers.
    logic [7:0]  r_carrier_period;
    logic [15:0] r_leader_mark;
    logic [15:0] r_leader_space;
    logic [15:0] r_bit_mark;
    logic [15:0] r_one_space;
    logic [15:0] r_zero_space;

    // Frame state.
    logic [nec_ir_pkg::SEG_W-1:0] r_seg, n_seg;
    logic [TIMER_WIDTH-1:0]       r_timer, n_timer;
    logic [7:0]                   r_phase, n_phase;
    logic [31:0]                  r_shift, n_shift;
    logic                         r_active, n_active;

    // Output buffer: main register and skid register.
    logic                  r_out_valid, r_skid_valid;
    nec_ir_pkg::t_out_item r_out_data, r_skid_data;
    nec_ir_pkg::t_out_item n_result;

    logic                  in_accept;
    logic                  out_take;
    logic                  seg_data_space;
    logic                  next_is_mark;
    logic [15:0]           raw_len;
    logic [31:0]           len_wide;
    logic [TIMER_WIDTH-1:0] seg_len;
    logic [TIMER_WIDTH-1:0] timer_inc;
    logic [8:0]            phase_inc;
    logic [7:0]            addr_b, cmd_b;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_skid_valid;
    assign in_accept   = i_in_valid && !r_skid_valid;
    assign out_take    = r_out_valid && !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carrier_period <= nec_ir_pkg::RST_CARRIER_PERIOD;
            r_leader_mark    <= nec_ir_pkg::RST_LEADER_MARK;
            r_leader_space   <= nec_ir_pkg::RST_LEADER_SPACE;
            r_bit_mark       <= nec_ir_pkg::RST_BIT_MARK;
            r_one_space      <= nec_ir_pkg::RST_ONE_SPACE;
            r_zero_space     <= nec_ir_pkg::RST_ZERO_SPACE;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                nec_ir_pkg::CFG_CARRIER_PERIOD: r_carrier_period <= i_cfg_data[7:0];
                nec_ir_pkg::CFG_LEADER_MARK:    r_leader_mark    <= i_cfg_data;
                nec_ir_pkg::CFG_LEADER_SPACE:   r_leader_space   <= i_cfg_data;
                nec_ir_pkg::CFG_BIT_MARK:       r_bit_mark       <= i_cfg_data;
                nec_ir_pkg::CFG_ONE_SPACE:      r_one_space      <= i_cfg_data;
                nec_ir_pkg::CFG_ZERO_SPACE:     r_zero_space     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Data spaces are the odd segments between the leader and the stop mark.
    assign seg_data_space = (r_seg >= nec_ir_pkg::SEG_FIRST_BIT) &&
                            (r_seg < nec_ir_pkg::SEG_STOP) && r_seg[0];

    // Length of the current segment, forced to at least one tick and
    // saturated to what the timer can hold.
    always_comb begin
        priority if (r_seg == nec_ir_pkg::SEG_LEADER_MARK) begin
            raw_len = r_leader_mark;
        end else if (r_seg == nec_ir_pkg::SEG_LEADER_SPACE) begin
            raw_len = r_leader_space;
        end else if (seg_data_space) begin
            raw_len = r_shift[0] ? r_one_space : r_zero_space;
        end else begin
            raw_len = r_bit_mark;
        end
        len_wide = {16'd0, raw_len};
        if (len_wide == 32'd0) begin
            len_wide = 32'd1;
        end
        if (len_wide > TIMER_MAX) begin
            len_wide = TIMER_MAX;
        end
        seg_len = len_wide[TIMER_WIDTH-1:0];
    end

    assign timer_inc = r_timer + {{(TIMER_WIDTH-1){1'b0}}, 1'b1};
    assign phase_inc = {1'b0, r_phase} + 9'd1;
    assign addr_b    = i_in_data.address_byte;
    assign cmd_b     = i_in_data.command_byte;

    // Next frame state for one item.
    always_comb begin
        n_seg    = r_seg;
        n_timer  = r_timer;
        n_phase  = r_phase;
        n_shift  = r_shift;
        n_active = r_active;
        n_result = '0;
        if (i_in_data.req_type == nec_ir_pkg::REQ_SEND) begin
            // A request while busy is ignored.
            if (!r_active) begin
                n_shift  = {~cmd_b, cmd_b, ~addr_b, addr_b};
                n_seg    = nec_ir_pkg::SEG_LEADER_MARK;
                n_timer  = '0;
                n_phase  = '0;
                n_active = 1'b1;
                n_result.accepted = 1'b1;
            end
        end else if (r_active) begin
            n_phase = (phase_inc >= {1'b0, r_carrier_period}) ? 8'd0 : phase_inc[7:0];
            n_timer = timer_inc;
            if (timer_inc >= seg_len) begin
                if (seg_data_space) begin
                    n_shift = {1'b0, r_shift[31:1]};
                end
                n_timer = '0;
                n_phase = '0;
                if (r_seg == nec_ir_pkg::SEG_STOP) begin
                    n_seg    = nec_ir_pkg::SEG_LEADER_MARK;
                    n_active = 1'b0;
                    n_result.frame_done = 1'b1;
                end else begin
                    n_seg = r_seg + 7'd1;
                end
            end
        end

        // LED level after this item: carrier high half during a mark.
        next_is_mark = (n_seg == nec_ir_pkg::SEG_LEADER_MARK) ||
                       (n_seg == nec_ir_pkg::SEG_STOP) ||
                       ((n_seg >= nec_ir_pkg::SEG_FIRST_BIT) &&
                        (n_seg < nec_ir_pkg::SEG_STOP) && !n_seg[0]);
        n_result.ir_level = n_active && next_is_mark &&
                            (n_phase >= {1'b0, r_carrier_period[7:1]});
        n_result.busy_res = n_active;
    end

    // Frame state registers, updated at each accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg    <= '0;
            r_timer  <= '0;
            r_phase  <= '0;
            r_shift  <= '0;
            r_active <= 1'b0;
        end else if (in_accept) begin
            r_seg    <= n_seg;
            r_timer  <= n_timer;
            r_phase  <= n_phase;
            r_shift  <= n_shift;
            r_active <= n_active;
        end
    end

    // Output buffer: a new result goes to the main register when it is free
    // or being emptied, otherwise to the skid register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || out_take) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= in_accept;
                end
            end else if (in_accept) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                r_out_data <= r_skid_data;
            end else begin
                r_out_data <= n_result;
            end
        end
        if (in_accept && r_out_valid && !out_take) begin
            r_skid_data <= n_result;
        end
    end

endmodule

// File: tb/sv/nec_ir_check_pkg.sv
// ----------------------------------------------------------------------------
// NEC IR transmitter frame scoreboard
// Follows the frame that the transmitter should be playing out, item by
// item, and checks every result item against the level, busy, accepted and
// done flags that the frame calls for.
// ----------------------------------------------------------------------------
package nec_ir_check_pkg;
    import nec_ir_pkg::*;

    localparam int unsigned TICK_TIMER_WIDTH = 16;
    localparam int unsigned TICK_TIMER_MASK  = (1 << TICK_TIMER_WIDTH) - 1;

    class nec_frame_scoreboard;
        // Timing registers as the block should hold them.
        logic [7:0]  carrier_period = RST_CARRIER_PERIOD;
        logic [15:0] leader_mark    = RST_LEADER_MARK;
        logic [15:0] leader_space   = RST_LEADER_SPACE;
        logic [15:0] bit_mark       = RST_BIT_MARK;
        logic [15:0] one_space      = RST_ONE_SPACE;
        logic [15:0] zero_space     = RST_ZERO_SPACE;

        // Progress through the current frame.
        int unsigned seg_index     = 0;
        int unsigned seg_timer     = 0;
        int unsigned carrier_phase = 0;
        logic [31:0] frame_bits    = '0;
        bit          sending       = 1'b0;

        t_out_item   owed_results[$];
        int unsigned fault_count = 0;

        // A write takes effect at once, even in the middle of a frame.
        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
            case (index)
                CFG_CARRIER_PERIOD: carrier_period = value[7:0];
                CFG_LEADER_MARK:    leader_mark    = value;
                CFG_LEADER_SPACE:   leader_space   = value;
                CFG_BIT_MARK:       bit_mark       = value;
                CFG_ONE_SPACE:      one_space      = value;
                CFG_ZERO_SPACE:     zero_space     = value;
                default: ;
            endcase
        endfunction

        function bit seg_is_mark(int unsigned seg);
            if (seg == SEG_LEADER_MARK || seg == SEG_STOP) return 1'b1;
            return seg >= SEG_FIRST_BIT && seg < SEG_STOP && (seg - SEG_FIRST_BIT) % 2 == 0;
        endfunction

        function bit seg_is_bit_space(int unsigned seg);
            return seg >= SEG_FIRST_BIT && seg < SEG_STOP && (seg - SEG_FIRST_BIT) % 2 == 1;
        endfunction

        // Length of a segment in ticks; a zero length counts as one tick.
        function int unsigned seg_ticks(int unsigned seg);
            int unsigned len;
            if (seg == SEG_LEADER_MARK) begin
                len = leader_mark;
            end else if (seg == SEG_LEADER_SPACE) begin
                len = leader_space;
            end else if (seg_is_bit_space(seg)) begin
                len = frame_bits[0] ? one_space : zero_space;
            end else begin
                len = bit_mark;
            end
            if (len == 0) len = 1;
            if (len > TICK_TIMER_MASK) len = TICK_TIMER_MASK;
            return len;
        endfunction

        // Plays one accepted item into the frame and queues the result it owes.
        function void advance_frame(t_in_item it);
            t_out_item   res;
            int unsigned next_phase;
            res = '0;
            if (it.req_type == REQ_SEND) begin
                // A request is only taken while no frame is in progress.
                if (!sending) begin
                    frame_bits    = {~it.command_byte, it.command_byte,
                                     ~it.address_byte, it.address_byte};
                    seg_index     = SEG_LEADER_MARK;
                    seg_timer     = 0;
                    carrier_phase = 0;
                    sending       = 1'b1;
                    res.accepted  = 1'b1;
                end
            end else if (sending) begin
                // A phase at or past a shortened period wraps to zero.
                next_phase    = carrier_phase + 1;
                carrier_phase = (next_phase >= carrier_period) ? 0 : (next_phase & 8'hFF);
                seg_timer     = (seg_timer + 1) & TICK_TIMER_MASK;
                if (seg_timer >= seg_ticks(seg_index)) begin
                    if (seg_is_bit_space(seg_index)) frame_bits = frame_bits >> 1;
                    seg_index++;
                    seg_timer     = 0;
                    carrier_phase = 0;
                    if (seg_index > SEG_STOP) begin
                        seg_index      = SEG_LEADER_MARK;
                        sending        = 1'b0;
                        res.frame_done = 1'b1;
                    end
                end
            end
            // The carrier is low for the first half of its period, then high.
            res.ir_level = sending && seg_is_mark(seg_index)
                           && (carrier_phase >= (carrier_period >> 1));
            res.busy_res = sending;
            owed_results.push_back(res);
        endfunction

        function void report(string field, logic want, logic got);
            fault_count++;
            $error("%s: expected %b, got %b", field, want, got);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (owed_results.size() == 0) begin
                fault_count++;
                $error("result item %b arrived with none expected", got);
                return;
            end
            want = owed_results.pop_front();
            if (got.ir_level   !== want.ir_level)   report("ir_level", want.ir_level, got.ir_level);
            if (got.busy_res   !== want.busy_res)   report("busy_res", want.busy_res, got.busy_res);
            if (got.accepted   !== want.accepted)   report("accepted", want.accepted, got.accepted);
            if (got.frame_done !== want.frame_done) begin
                report("frame_done", want.frame_done, got.frame_done);
            end
        endfunction

        function int unsigned waiting();
            return owed_results.size();
        endfunction

        function void close_out();
            if (owed_results.size() != 0) begin
                fault_count++;
                $error("%0d result items never arrived", owed_results.size());
            end
        endfunction
    endclass

endpackage

// File: tb/sv/nec_ir_transmitter_top_test.sv
// ----------------------------------------------------------------------------
// NEC IR transmitter testbench
// Drives ticks and send requests through the transmitter under several
// timing settings, from the reset timings to zero, minimum and maximum
// lengths, with random gaps on both sides, and checks each result item.
// ----------------------------------------------------------------------------
module nec_ir_transmitter_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import nec_ir_pkg::*;
    import nec_ir_check_pkg::*;

    // The run sends somewhat over a thousand items; the limit ends a run that hangs.
    localparam int unsigned CYCLE_LIMIT = 100_000;

    // Indexes past the last register, which the block must ignore.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    t_in_item              in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    bit                    steady_flow = 1'b0;
    int unsigned           cycle_count = 0;
    nec_frame_scoreboard   board;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    nec_ir_transmitter_top #(
        .TIMER_WIDTH(TICK_TIMER_WIDTH)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // The result side holds off at random, except in the steady stretches.
    always @(negedge clk) begin
        out_stall <= !steady_flow && ($urandom_range(99) < 28);
    end

    // Results are taken at the rising edge; the cycle count guards against a hang.
    always @(posedge clk) begin
        cycle_count++;
        if (rst_n && out_valid && !out_stall) board.check_result(out_data);
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[nec_ir_transmitter_top] ERROR");
            $finish;
        end
    end

    function automatic t_in_item make_item(logic kind);
        t_in_item it;
        it.req_type     = kind;
        it.address_byte = 8'($urandom);
        it.command_byte = 8'($urandom);
        return it;
    endfunction

    // Offers one item, with a random gap first, and waits until it is taken.
    task automatic push_item(t_in_item it);
        @(negedge clk);
        while (!steady_flow && $urandom_range(99) < 28) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (in_stall);
        board.advance_frame(it);
    endtask

    // Stops offering items and waits for every owed result.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (board.waiting() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        board.write_reg(index, value);
    endtask

    task automatic set_timing(int unsigned period, int unsigned lead_mark,
                              int unsigned lead_space, int unsigned mark,
                              int unsigned one, int unsigned zero);
        write_reg(CFG_CARRIER_PERIOD, CFG_DATA_W'(period));
        write_reg(CFG_LEADER_MARK, CFG_DATA_W'(lead_mark));
        write_reg(CFG_LEADER_SPACE, CFG_DATA_W'(lead_space));
        write_reg(CFG_BIT_MARK, CFG_DATA_W'(mark));
        write_reg(CFG_ONE_SPACE, CFG_DATA_W'(one));
        write_reg(CFG_ZERO_SPACE, CFG_DATA_W'(zero));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly frames: a request when idle, then ticks, with a few requests
    // thrown in while busy. Items that the block ignores are not counted.
    task automatic random_run(int unsigned budget);
        int unsigned counted;
        t_in_item    it;
        bit          ignored;
        counted = 0;
        while (counted < budget) begin
            if (board.sending) begin
                it = make_item(($urandom_range(99) < 4) ? REQ_SEND : REQ_TICK);
            end else begin
                it = make_item(($urandom_range(99) < 85) ? REQ_SEND : REQ_TICK);
            end
            ignored = (it.req_type == REQ_SEND && board.sending)
                      || (it.req_type == REQ_TICK && !board.sending);
            push_item(it);
            if (!ignored) counted++;
        end
    endtask

    // Starts a frame if none is running and ticks it through to the end.
    task automatic play_frame();
        if (!board.sending) push_item(make_item(REQ_SEND));
        while (board.sending) push_item(make_item(REQ_TICK));
    endtask

    initial begin
        board = new();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset timings: a tick while idle, a request with extreme bytes, a
        // request while busy, then the opening ticks of the leader mark, long
        // enough for the default carrier to turn on and wrap.
        push_item(t_in_item'{REQ_TICK, 8'hFF, 8'hFF});
        push_item(t_in_item'{REQ_SEND, 8'hFF, 8'h00});
        push_item(t_in_item'{REQ_SEND, 8'h00, 8'hFF});
        repeat (40) push_item(make_item(REQ_TICK));
        settle();

        // Shortest legal carrier and single-tick segments, cutting the
        // leader mark short.
        set_timing(2, 1, 1, 1, 1, 1);
        random_run(100);
        settle();

        // Zero lengths behave as one tick; a zero carrier is always on.
        // Writes to the spare indexes must change nothing.
        write_reg(CFG_SPARE_LO, 16'hFFFF);
        write_reg(CFG_SPARE_HI, 16'h0001);
        set_timing(0, 0, 0, 0, 0, 0);
        random_run(100);
        settle();

        // A carrier period of one is also always on.
        set_timing(1, $urandom_range(4, 1), $urandom_range(4, 1), $urandom_range(4, 1),
                   $urandom_range(4, 1), $urandom_range(4, 1));
        random_run(100);
        settle();

        // No gaps on either side; the carrier's upper data byte is dropped.
        steady_flow = 1'b1;
        set_timing('hFF03, $urandom_range(6, 0), $urandom_range(6, 0),
                   $urandom_range(6, 0), $urandom_range(6, 0), $urandom_range(6, 0));
        random_run(150);
        settle();
        steady_flow = 1'b0;

        // Longest carrier with long bit marks, so the next phase lands mid-mark.
        set_timing(255, $urandom_range(3, 1), $urandom_range(3, 1), 300,
                   $urandom_range(3, 1), $urandom_range(3, 1));
        random_run(150);
        settle();

        // Carrier shortened during a mark; longest bit timings.
        set_timing(5, 1, 1, 'hFFFF, 'hFFFF, 'hFFFF);
        random_run(100);
        settle();

        // Back to short timings, which cut the long segment short.
        set_timing($urandom_range(40, 2), $urandom_range(3, 1), $urandom_range(3, 1),
                   $urandom_range(3, 1), $urandom_range(3, 1), $urandom_range(3, 1));
        random_run(100);
        play_frame();
        settle();

        // Random carrier and short random lengths.
        set_timing($urandom_range(255, 0), $urandom_range(5, 0), $urandom_range(5, 0),
                   $urandom_range(5, 0), $urandom_range(5, 0), $urandom_range(5, 0));
        random_run(100);
        settle();

        board.close_out();
        if (board.fault_count == 0) begin
            $display("[nec_ir_transmitter_top] OK");
        end else begin
            $display("[nec_ir_transmitter_top] ERROR");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/nec_ir_pkg.sv
design/nec_ir_transmitter_top.sv
tb/sv/nec_ir_check_pkg.sv
tb/sv/nec_ir_transmitter_top_test.sv
